// ----- rtl/core/sbrs_pkg.sv -----
// shared types and constants of the scrambled bpsk rrc shaper
package sbrs_pkg;

    localparam int OVERSAMPLE_DEF = 4;
    localparam int MAX_TAPS_DEF   = 48;

    localparam int TAP_IDX_W  = 6;
    localparam int TAP_W      = 16;
    localparam int SAMPLE_W   = 22;
    localparam int SCR_W      = 23;
    localparam int TIU_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    localparam int SAMPLE_MAX = 2097151;
    localparam int SAMPLE_MIN = -2097152;

    localparam logic [TIU_W-1:0] TIU_RST = 6'd45;
    localparam logic [SCR_W-1:0] SCR_RST = '0;

    // scrambler feedback taps for x^23 + x^18 + 1
    localparam int SCR_TAP_A = 22;
    localparam int SCR_TAP_B = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_TAPS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_SEED    = 2'd1;

    typedef enum logic {
        REQ_TAP  = 1'b0,
        REQ_DATA = 1'b1
    } t_req;

    typedef struct packed {
        logic                 we;
        logic [TAP_IDX_W-1:0] idx;
        logic [TAP_W-1:0]     value;
    } t_tap_wr;

    typedef struct packed {
        logic vld;
        logic sbit;
    } t_iss;

endpackage

// ----- rtl/core/sbrs_if.sv -----
// valid/ready channel interfaces for input items, samples and register writes
interface sbrs_in_if import sbrs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [TAP_IDX_W-1:0]       tap_index;
    logic signed [TAP_W-1:0]    tap_value;
    logic                       data_bit;

    modport source (output valid, req_type, tap_index, tap_value, data_bit, input ready);
    modport sink   (input valid, req_type, tap_index, tap_value, data_bit, output ready);
endinterface

interface sbrs_out_if import sbrs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [1:0]                 phase;
    logic                       scrambled_bit;
    logic                       last_of_symbol;

    modport source (output valid, sample_out, phase, scrambled_bit, last_of_symbol,
                    input ready);
    modport sink   (input valid, sample_out, phase, scrambled_bit, last_of_symbol,
                    output ready);
endinterface

interface sbrs_cfg_if import sbrs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/sbrs_filter.sv -----
// polyphase tap memory, term selection, adder tree and output register
module sbrs_filter import sbrs_pkg::*; #(
    parameter int OVERSAMPLE = OVERSAMPLE_DEF,
    parameter int MAX_TAPS   = MAX_TAPS_DEF,
    localparam int HD        = (MAX_TAPS + OVERSAMPLE - 1) / OVERSAMPLE,
    localparam int PH_W      = $clog2(OVERSAMPLE)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tap_wr           i_tap_wr,
    input  t_iss              i_iss,
    input  logic [PH_W-1:0]   i_phase,
    input  logic [HD-1:0]     i_hpres,
    input  logic [HD-1:0]     i_hneg,
    input  logic [TIU_W-1:0]  i_tiu,
    output logic              o_iss_rdy,
    sbrs_out_if.source        o_out
);

    localparam int NG     = (HD + 3) / 4;
    localparam int PART_W = TAP_W + 3;
    localparam int ACC_W  = PART_W + $clog2(NG + 1) + 4;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SAMPLE_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SAMPLE_MIN);
    localparam logic [PH_W-1:0]         PH_LAST = PH_W'(OVERSAMPLE - 1);

    // row q holds taps q, q+OVERSAMPLE, q+2*OVERSAMPLE, ... one per lane
    logic [TAP_W-1:0] mem [OVERSAMPLE][HD];
    logic             r_tv [MAX_TAPS];
    logic [OVERSAMPLE-1:0] w_hit [HD];

    logic                     r_b_v, r_c_v, r_d_v;
    logic                     b_rdy, c_rdy, d_rdy, w_issue;
    logic [TAP_W-1:0]         r_b_tap [HD];
    logic [HD-1:0]            r_b_mask, r_b_neg, n_mask;
    logic [PH_W-1:0]          r_b_phase, r_c_phase, r_d_phase;
    logic                     r_b_bit, r_c_bit, r_d_bit, r_d_last;
    logic signed [PART_W-1:0] n_part [NG];
    logic signed [PART_W-1:0] r_c_part [NG];
    logic signed [ACC_W-1:0]  n_acc, n_sat;
    logic signed [SAMPLE_W-1:0] r_d_sample;

    assign d_rdy     = !r_d_v || o_out.ready;
    assign c_rdy     = !r_c_v || d_rdy;
    assign b_rdy     = !r_b_v || c_rdy;
    assign w_issue   = i_iss.vld && b_rdy;
    assign o_iss_rdy = b_rdy;

    genvar t, l, q;
    generate
        for (t = 0; t < MAX_TAPS; t++) begin : g_tap
            localparam int R = t % OVERSAMPLE;
            localparam int L = t / OVERSAMPLE;
            always_ff @(posedge i_clk) begin
                if (i_tap_wr.we && int'(i_tap_wr.idx) == t) begin
                    mem[R][L] <= i_tap_wr.value;
                end
            end
            // never-loaded taps read as zero
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_tv[t] <= 1'b0;
                end else if (i_tap_wr.we && int'(i_tap_wr.idx) == t) begin
                    r_tv[t] <= 1'b1;
                end
            end
        end

        for (l = 0; l < HD; l++) begin : g_lane
            for (q = 0; q < OVERSAMPLE; q++) begin : g_ph
                localparam int T = q + OVERSAMPLE * l;
                if (T < MAX_TAPS) begin : g_in
                    assign w_hit[l][q] = r_tv[T] && (int'(i_tiu) > T);
                end else begin : g_out
                    assign w_hit[l][q] = 1'b0;
                end
            end
            assign n_mask[l] = w_hit[l][i_phase] & i_hpres[l];

            always_ff @(posedge i_clk) begin
                if (w_issue) begin
                    r_b_tap[l] <= mem[i_phase][l];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            if (b_rdy) begin
                r_b_v <= w_issue;
            end
            if (c_rdy) begin
                r_c_v <= r_b_v;
            end
            if (d_rdy) begin
                r_d_v <= r_c_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_b_mask  <= n_mask;
            r_b_neg   <= i_hneg;
            r_b_phase <= i_phase;
            r_b_bit   <= i_iss.sbit;
        end
    end

    // signed terms summed in groups of four lanes
    always_comb begin
        int li;
        for (int g = 0; g < NG; g++) begin
            n_part[g] = '0;
            for (int k = 0; k < 4; k++) begin
                li = 4 * g + k;
                if (li < HD) begin
                    if (r_b_mask[li]) begin
                        if (r_b_neg[li]) begin
                            n_part[g] = n_part[g] - PART_W'($signed(r_b_tap[li]));
                        end else begin
                            n_part[g] = n_part[g] + PART_W'($signed(r_b_tap[li]));
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_rdy && r_b_v) begin
            r_c_part  <= n_part;
            r_c_phase <= r_b_phase;
            r_c_bit   <= r_b_bit;
        end
    end

    always_comb begin
        n_acc = '0;
        for (int g = 0; g < NG; g++) begin
            n_acc = n_acc + ACC_W'(r_c_part[g]);
        end
        if (n_acc > SAT_HI) begin
            n_sat = SAT_HI;
        end else if (n_acc < SAT_LO) begin
            n_sat = SAT_LO;
        end else begin
            n_sat = n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_rdy && r_c_v) begin
            r_d_sample <= SAMPLE_W'(n_sat);
            r_d_phase  <= r_c_phase;
            r_d_bit    <= r_c_bit;
            r_d_last   <= (r_c_phase == PH_LAST);
        end
    end

    assign o_out.valid          = r_d_v;
    assign o_out.sample_out     = r_d_sample;
    assign o_out.phase          = 2'(r_d_phase);
    assign o_out.scrambled_bit  = r_d_bit;
    assign o_out.last_of_symbol = r_d_last;

endmodule

// ----- rtl/core/scrambled_bpsk_rrc_shaper_top.sv -----
// Scrambled BPSK root-raised-cosine pulse shaper.
// i_in carries items: req_type 0 loads tap_value into tap tap_index, req_type 1
// carries one data bit. The bit is scrambled (x^23+x^18+1, self-synchronizing),
// mapped to +1/-1 and shaped by a polyphase FIR whose taps sit in a memory with
// one row per phase, all taps of a phase in one row.
// o_out gives OVERSAMPLE samples per data bit, phase 0 first, last_of_symbol on
// the final one. i_cfg writes taps_in_use (index 0) and scrambler_seed (index 1,
// also reloads the scrambler); it is always ready and is to be used only while
// idle; the block does not enforce this. A bit's first sample passes the phase
// sequencer and filter registers b, c and d. Bits are read one phase row per
// cycle while the filter is ready, via the single read port of the tap memory.
// A new beat is taken in the cycle the last phase of the previous bit is read,
// so bits flow without gaps. A stalled receiver fills stages d, c and b and the
// phase sequencer, then the input deasserts ready. Reset (synchronous, active
// low) marks taps unloaded (they read as zero), clears the symbol history, the
// scrambler state and the pipeline, and sets taps_in_use to 45.
module scrambled_bpsk_rrc_shaper_top import sbrs_pkg::*; #(
    parameter int OVERSAMPLE = OVERSAMPLE_DEF,
    parameter int MAX_TAPS   = MAX_TAPS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbrs_in_if.sink    i_in,
    sbrs_cfg_if.sink   i_cfg,
    sbrs_out_if.source o_out
);

    localparam int HD   = (MAX_TAPS + OVERSAMPLE - 1) / OVERSAMPLE;
    localparam int PH_W = $clog2(OVERSAMPLE);
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(OVERSAMPLE - 1);

    logic [SCR_W-1:0] r_scr;
    logic [TIU_W-1:0] r_tiu;
    logic             r_busy, r_bit;
    logic [PH_W-1:0]  r_phase;
    logic [HD-1:0]    r_hpres, r_hneg;
    logic             w_iss_rdy, w_accept, w_data, n_bit;
    t_tap_wr          w_tap_wr;
    t_iss             w_iss;

    assign i_in.ready = !r_busy || (r_phase == PH_LAST && w_iss_rdy);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_data     = w_accept && (i_in.req_type == REQ_DATA);
    assign n_bit      = i_in.data_bit ^ r_scr[SCR_TAP_A] ^ r_scr[SCR_TAP_B];

    assign w_tap_wr.we    = w_accept && (i_in.req_type == REQ_TAP);
    assign w_tap_wr.idx   = i_in.tap_index;
    assign w_tap_wr.value = i_in.tap_value;

    assign w_iss.vld  = r_busy;
    assign w_iss.sbit = r_bit;

    assign i_cfg.ready = 1'b1;

    // configuration and scrambler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiu <= TIU_RST;
            r_scr <= SCR_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_TAPS_IN_USE: r_tiu <= i_cfg.data[TIU_W-1:0];
                CFG_SCR_SEED:    r_scr <= i_cfg.data[SCR_W-1:0];
                default: ;
            endcase
        end else if (w_data) begin
            r_scr <= {r_scr[SCR_W-2:0], n_bit};
        end
    end

    // symbol history: present flag and sign, newest in lane 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hpres <= '0;
            r_hneg  <= '0;
        end else if (w_data) begin
            r_hpres[0] <= 1'b1;
            r_hneg[0]  <= ~n_bit;
            for (int i = 1; i < HD; i++) begin
                r_hpres[i] <= r_hpres[i-1];
                r_hneg[i]  <= r_hneg[i-1];
            end
        end
    end

    // phase sequencer: one tap row read per cycle while the filter is ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= '0;
        end else if (w_data) begin
            r_busy  <= 1'b1;
            r_phase <= '0;
        end else if (r_busy && w_iss_rdy) begin
            if (r_phase == PH_LAST) begin
                r_busy <= 1'b0;
            end else begin
                r_phase <= r_phase + PH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_data) begin
            r_bit <= n_bit;
        end
    end

    sbrs_filter #(
        .OVERSAMPLE (OVERSAMPLE),
        .MAX_TAPS   (MAX_TAPS)
    ) u_filter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tap_wr  (w_tap_wr),
        .i_iss     (w_iss),
        .i_phase   (r_phase),
        .i_hpres   (r_hpres),
        .i_hneg    (r_hneg),
        .i_tiu     (r_tiu),
        .o_iss_rdy (w_iss_rdy),
        .o_out     (o_out)
    );

endmodule

// ----- bench/tb.sv -----
// testbench of the scrambled bpsk rrc shaper: predicted samples checked beat by beat
`timescale 1ns / 100ps

import sbrs_pkg::*;

typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [1:0]                 phase;
    logic                       sbit;
    logic                       last;
} t_sample_beat;

class shaper_scoreboard;
    localparam int HIST_LEN = (MAX_TAPS_DEF + OVERSAMPLE_DEF - 1) / OVERSAMPLE_DEF;

    logic [TIU_W-1:0]        taps_in_use;
    logic [SCR_W-1:0]        scr_state;
    int                      symbols [HIST_LEN];
    logic signed [TAP_W-1:0] coeff [MAX_TAPS_DEF];
    t_sample_beat            expected_samples [$];
    int                      mismatches;
    int                      beat_cnt;

    function new();
        taps_in_use = TIU_RST;
        scr_state   = SCR_RST;
        foreach (symbols[i]) symbols[i] = 0;
        foreach (coeff[i]) coeff[i] = '0;
        mismatches = 0;
        beat_cnt   = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_TAPS_IN_USE: taps_in_use = data[TIU_W-1:0];
            CFG_SCR_SEED:    scr_state = data[SCR_W-1:0];
            default: ;
        endcase
    endfunction

    // store a tap load, or scramble a data bit, map to +-1 and run every polyphase branch of the fir
    function void take_item(t_req req, logic [TAP_IDX_W-1:0] idx,
                            logic signed [TAP_W-1:0] value, logic dbit);
        logic         sbit;
        int           limit;
        int           acc;
        int           t;
        t_sample_beat beat;
        if (req == REQ_TAP) begin
            if (idx < MAX_TAPS_DEF) coeff[idx] = value;
            return;
        end
        sbit = dbit ^ scr_state[SCR_TAP_A] ^ scr_state[SCR_TAP_B];
        scr_state = {scr_state[SCR_W-2:0], sbit};
        for (int i = HIST_LEN - 1; i > 0; i--) symbols[i] = symbols[i-1];
        symbols[0] = sbit ? 1 : -1;
        limit = (taps_in_use > MAX_TAPS_DEF) ? MAX_TAPS_DEF : int'(taps_in_use);
        for (int p = 0; p < OVERSAMPLE_DEF; p++) begin
            acc = 0;
            for (int i = 0; i < HIST_LEN; i++) begin
                t = p + OVERSAMPLE_DEF * i;
                if (t >= limit) break;
                acc += symbols[i] * int'(coeff[t]);
            end
            if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
            if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
            beat.sample = acc[SAMPLE_W-1:0];
            beat.phase  = p[1:0];
            beat.sbit   = sbit;
            beat.last   = (p == OVERSAMPLE_DEF - 1);
            expected_samples.push_back(beat);
        end
    endfunction

    task report(string msg);
        $display("sample beat %0d: %s", beat_cnt, msg);
        mismatches++;
    endtask

    task check_sample(t_sample_beat got);
        t_sample_beat want;
        if (expected_samples.size() == 0) begin
            report("sample beat with nothing expected");
        end else begin
            want = expected_samples.pop_front();
            if (got.sample !== want.sample)
                report($sformatf("sample_out %0d, want %0d", got.sample, want.sample));
            if (got.phase !== want.phase)
                report($sformatf("phase %0d, want %0d", got.phase, want.phase));
            if (got.sbit !== want.sbit)
                report($sformatf("scrambled_bit %0b, want %0b", got.sbit, want.sbit));
            if (got.last !== want.last)
                report($sformatf("last_of_symbol %0b, want %0b", got.last, want.last));
        end
        beat_cnt++;
    endtask

    function int pending();
        return expected_samples.size();
    endfunction
endclass

module tb;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic i_clk;
    logic i_rst_n;

    sbrs_in_if  in_ch ();
    sbrs_out_if out_ch ();
    sbrs_cfg_if cfg_ch ();

    scrambled_bpsk_rrc_shaper_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    shaper_scoreboard sb;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_req      = 0;
    int hold_left     = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_sample({out_ch.sample_out, out_ch.phase, out_ch.scrambled_bit,
                             out_ch.last_of_symbol});
    end

    task automatic send_item(t_req req, logic [TAP_IDX_W-1:0] idx,
                             logic [TAP_W-1:0] value, logic dbit);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.req_type  <= req;
        in_ch.tap_index <= idx;
        in_ch.tap_value <= value;
        in_ch.data_bit  <= dbit;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.take_item(req, idx, value, dbit);
    endtask

    task automatic random_item();
        logic [TAP_IDX_W-1:0] idx;
        logic [TAP_W-1:0]     value;
        idx   = TAP_IDX_W'($urandom);
        value = TAP_W'($urandom);
        if ($urandom_range(99) < 22) begin
            if ($urandom_range(9) != 0) idx = TAP_IDX_W'($urandom_range(MAX_TAPS_DEF - 1));
            case ($urandom_range(7))
                0: value = 16'h7FFF;
                1: value = 16'h8000;
                default: ;
            endcase
            send_item(REQ_TAP, idx, value, 1'($urandom_range(1)));
        end else begin
            send_item(REQ_DATA, idx, value, 1'($urandom_range(1)));
        end
    endtask

    // drain every sample, then let a trailing tap load settle
    task automatic wait_idle();
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_registers(logic [TIU_W-1:0] tiu, logic [SCR_W-1:0] seed, bit spare);
        logic [CFG_IDX_W-1:0]  idxs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        int n;
        idxs[0] = CFG_TAPS_IN_USE;
        vals[0] = {(CFG_DATA_W - TIU_W)'($urandom), tiu};
        idxs[1] = CFG_SCR_SEED;
        vals[1] = seed;
        idxs[2] = CFG_SPARE_2;
        vals[2] = CFG_DATA_W'($urandom);
        idxs[3] = CFG_SPARE_3;
        vals[3] = CFG_DATA_W'($urandom);
        n = spare ? 4 : 2;
        for (int k = 0; k < n; k++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idxs[k];
            cfg_ch.data  <= vals[k];
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
            sb.write_register(idxs[k], vals[k]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_random(int n, int hold, bit pause_midway);
        if (hold > 0) hold_req = hold;
        for (int k = 0; k < n; k++) begin
            if (pause_midway && k == n / 2) begin
                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (sb.pending() != 0);
            end
            random_item();
        end
        in_ch.valid <= 1'b0;
    endtask

    initial begin
        sb = new();
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.req_type  = REQ_TAP;
        in_ch.tap_index = '0;
        in_ch.tap_value = '0;
        in_ch.data_bit  = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_TAPS_IN_USE;
        cfg_ch.data     = '0;
        out_ch.ready    = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 29;
        sink_idle_pct = 68;
        // symbols through an all-zero filter
        send_item(REQ_DATA, '0, '0, 1'b1);
        send_item(REQ_DATA, 6'd63, 16'hFFFF, 1'b0);
        // tap extremes, taps past taps_in_use and loads beyond the store, then symbols
        send_item(REQ_TAP, 6'd0, 16'h7FFF, 1'b0);
        send_item(REQ_TAP, 6'd1, 16'h8000, 1'b1);
        send_item(REQ_TAP, 6'd2, 16'h5555, 1'b0);
        send_item(REQ_TAP, 6'd3, 16'hAAAA, 1'b1);
        send_item(REQ_TAP, 6'd4, 16'h0001, 1'b0);
        send_item(REQ_TAP, 6'd44, 16'h8000, 1'b0);
        send_item(REQ_TAP, 6'd45, 16'h7FFF, 1'b1);
        send_item(REQ_TAP, 6'd47, 16'hFFFF, 1'b0);
        send_item(REQ_TAP, 6'd48, 16'h1234, 1'b1);
        send_item(REQ_TAP, 6'd63, 16'hFFFF, 1'b1);
        send_item(REQ_DATA, 6'd63, 16'h8000, 1'b1);
        send_item(REQ_DATA, 6'd0, 16'h7FFF, 1'b0);
        send_item(REQ_DATA, 6'd21, 16'h8000, 1'b1);
        send_item(REQ_DATA, 6'd42, 16'h7FFF, 1'b1);
        send_item(REQ_DATA, 6'd63, 16'h0000, 1'b0);
        send_item(REQ_DATA, 6'd0, 16'hFFFF, 1'b0);
        send_item(REQ_DATA, 6'd5, 16'h1234, 1'b1);
        send_item(REQ_DATA, 6'd50, 16'h4321, 1'b1);
        in_ch.valid <= 1'b0;

        wait_idle();
        write_registers(6'd48, 23'h7FFFFF, 1'b1);
        run_random(60, 0, 1'b0);
        wait_idle();
        write_registers(6'd0, SCR_W'($urandom), 1'b0);
        run_random(30, 0, 1'b0);

        src_idle_pct  = 68;
        sink_idle_pct = 29;
        wait_idle();
        write_registers(6'd63, 23'h000000, 1'b1);
        run_random(60, 0, 1'b0);
        wait_idle();
        write_registers(6'd1, SCR_W'($urandom), 1'b0);
        run_random(40, 0, 1'b0);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        wait_idle();
        write_registers(TIU_W'($urandom_range(47, 2)), SCR_W'($urandom), 1'b0);
        run_random(90, 300, 1'b1);
        wait_idle();
        write_registers(6'd45, SCR_W'($urandom), 1'b0);
        run_random(100, 0, 1'b0);

        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (12) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- scrambled_bpsk_rrc_shaper_top.f -----
rtl/core/sbrs_pkg.sv
rtl/core/sbrs_if.sv
rtl/core/sbrs_filter.sv
rtl/core/scrambled_bpsk_rrc_shaper_top.sv
bench/tb.sv
